>>> rtl/core/wwg_pkg.sv
// Shared types and constants for the Wireworld generation stencil.
package wwg_pkg;

   typedef logic [1:0] cell_type;
   typedef logic [7:0] group_type;

   typedef struct packed {
      group_type bot;
      group_type mid;
      group_type top;
   } column_type;

   localparam cell_type WW_EMPTY = 2'd0;
   localparam cell_type WW_WIRE  = 2'd1;
   localparam cell_type WW_HEAD  = 2'd2;
   localparam cell_type WW_TAIL  = 2'd3;

   localparam logic REG_WIDTH_GROUPS = 1'b0;
   localparam logic REG_GRID_ROWS    = 1'b1;

   localparam int WIDTH_W = 9;
   localparam int ROWS_W  = 13;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd256;
   localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd4096;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

endpackage

>>> rtl/core/wwg_ram.sv
// Generic single-write, single-read RAM with registered read-first data.
module wwg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wwg_lane.sv
// One cell lane: next Wireworld state from a 3x3 neighbourhood.
module wwg_lane (
   input  logic [5:0]        top,  // left, centre, right cells, lowest bits first
   input  logic [5:0]        mid,
   input  logic [5:0]        bot,
   output wwg_pkg::cell_type next_cell
);
   import wwg_pkg::*;

   logic [3:0] heads;
   cell_type   cur;

   always_comb begin
      heads = 4'd0;
      for (int k = 0; k < 3; k++) begin
         heads = heads + {3'd0, (cell_type'(top[2*k +: 2]) == WW_HEAD)};
         heads = heads + {3'd0, (cell_type'(bot[2*k +: 2]) == WW_HEAD)};
      end
      heads = heads + {3'd0, (cell_type'(mid[1:0]) == WW_HEAD)};
      heads = heads + {3'd0, (cell_type'(mid[5:4]) == WW_HEAD)};
   end

   assign cur = mid[3:2];

   always_comb begin
      case (cur)
         WW_HEAD: next_cell = WW_TAIL;
         WW_TAIL: next_cell = WW_WIRE;
         WW_WIRE: next_cell = (heads == 4'd1 || heads == 4'd2) ? WW_HEAD : WW_WIRE;
         default: next_cell = WW_EMPTY;
      endcase
   end

endmodule

>>> rtl/core/wwg_group.sv
// Four cell lanes side by side, merged into one packed next-state group.
module wwg_group (
   input  wwg_pkg::column_type left,
   input  wwg_pkg::column_type centre,
   input  wwg_pkg::column_type right,
   output wwg_pkg::group_type  next_group
);
   import wwg_pkg::*;

   logic [23:0] strip_top;
   logic [23:0] strip_mid;
   logic [23:0] strip_bot;
   cell_type    lane_out [4];

   assign strip_top = {right.top, centre.top, left.top};
   assign strip_mid = {right.mid, centre.mid, left.mid};
   assign strip_bot = {right.bot, centre.bot, left.bot};

   for (genvar i = 0; i < 4; i++) begin : g_lane
      // centre cell sits at position four plus lane in the twelve-cell strip
      wwg_lane u_lane (
         .top       (strip_top[2*i+6 +: 6]),
         .mid       (strip_mid[2*i+6 +: 6]),
         .bot       (strip_bot[2*i+6 +: 6]),
         .next_cell (lane_out[i])
      );
   end

   assign next_group = {lane_out[3], lane_out[2], lane_out[1], lane_out[0]};

endmodule

>>> rtl/core/wireworld_generation_stencil.sv
// Wireworld generation stencil top level: line store, window, lanes and result queue.
// Path: accepting the item at (row r, group g) loads the evaluation stage, whose result
//   for group g-1 of row r-1 goes to the queue; a row's last group adds a second result.
// Throughput: one item per cycle while the eight-entry queue has room, set by the line
//   store's single read port (read one item ahead); results leave one per ready cycle.
// Reset: counters, window, queue and configuration return to their defaults; the line
//   store is not cleared and needs no clearing pass.
module wireworld_generation_stencil #(
   parameter int MAX_GROUPS = 256,
   parameter int MAX_ROWS   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // cells
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // next_cells
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wwg_pkg::*;

   localparam int COL_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam logic [FIFO_CNT_W:0] READY_LIMIT = (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);

   // configuration
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [ROWS_W-1:0]  rows_ff, rows_in;
   logic               csr_wr;

   // raster position and window
   logic [COL_W-1:0] col_ff, col_in, col_step;
   logic [ROW_W-1:0] row_ff, row_in, row_step;
   column_type       win_prev_ff, win_prev_in;
   column_type       win_last_ff, win_last_in;
   column_type       cur_col;

   logic        req_fire;
   logic        last_col;
   logic        flush_row;
   logic        row_ge1;
   logic        row_ge2;
   logic [31:0] col_next_x;
   logic [31:0] row_x;
   group_type   incoming;

   // line store: upper byte is the row two above, lower byte the row above
   logic [15:0] ram_q;
   logic [15:0] line_q;
   logic [15:0] line_wr;
   logic        bypass_ff, bypass_in;
   logic [15:0] bypass_data_ff;

   // evaluation stage
   column_type s1_left_ff, s1_mid_ff, s1_right_ff;
   logic       s1_v1_ff, s1_v1_in;
   logic       s1_v2_in;
   logic       s1_last_ff;
   logic [1:0] s1_n_ff, s1_n_in;
   group_type  group_a;
   group_type  group_b;
   column_type zero_col;

   // result queue
   logic [8:0]            fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] fifo_wr_ff, fifo_wr_in;
   logic [FIFO_PTR_W-1:0] fifo_rd_ff, fifo_rd_in;
   logic [FIFO_CNT_W-1:0] fifo_count_ff, fifo_count_in;
   logic                  rsp_fire;
   logic [8:0]            slot0_data;
   logic [8:0]            slot1_data;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in = width_ff;
      rows_in  = rows_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_WIDTH_GROUPS: width_in = csr_pwdata[WIDTH_W-1:0];
            REG_GRID_ROWS:    rows_in  = csr_pwdata[ROWS_W-1:0];
            default:          width_in = width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WIDTH_GROUPS: csr_prdata = {{(32-WIDTH_W){1'b0}}, width_ff};
         REG_GRID_ROWS:    csr_prdata = {{(32-ROWS_W){1'b0}}, rows_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         rows_ff  <= ROWS_RESET;
      end else begin
         width_ff <= width_in;
         rows_ff  <= rows_in;
      end
   end

   // ---------------- raster position ----------------
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = ({1'b0, fifo_count_ff} + {{(FIFO_CNT_W-1){1'b0}}, s1_n_ff}) <= READY_LIMIT;

   assign col_next_x = 32'(col_ff) + 32'd1;
   assign row_x      = 32'(row_ff);

   // a column whose successor is at or past the effective width closes the row
   assign last_col = (width_ff == '0) || (col_next_x >= 32'(width_ff))
                     || (col_next_x >= 32'(MAX_GROUPS));
   assign flush_row = (rows_ff == '0) ? (row_x >= 32'd1)
                      : ((row_x >= 32'(rows_ff)) || (row_x >= 32'(MAX_ROWS)));
   assign row_ge1 = (row_ff != '0);
   assign row_ge2 = (row_ff > ROW_W'(1));

   assign col_step = last_col ? '0 : col_ff + COL_W'(1);
   assign row_step = flush_row ? '0 : row_ff + ROW_W'(1);
   assign col_in   = (req_fire && last_col) ? col_step : (req_fire ? col_step : col_ff);
   assign row_in   = (req_fire && last_col) ? row_step : row_ff;

   assign incoming = (!req_tuser && !flush_row) ? req_tdata : 8'd0;

   // ---------------- line store ----------------
   assign line_q  = bypass_ff ? bypass_data_ff : ram_q;
   assign line_wr = {line_q[7:0], incoming};

   // the store is read one item ahead; forward a write to the address read next
   assign bypass_in = req_fire && (col_in == col_ff);

   wwg_ram #(
      .WIDTH (16),
      .DEPTH (MAX_GROUPS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (line_wr),
      .rd_addr (col_in),
      .rd_data (ram_q)
   );

   always_comb begin
      cur_col.top = row_ge2 ? line_q[15:8] : 8'd0;
      cur_col.mid = row_ge1 ? line_q[7:0] : 8'd0;
      cur_col.bot = incoming;
   end

   always_comb begin
      win_prev_in = win_prev_ff;
      win_last_in = win_last_ff;
      if (req_fire) begin
         if (last_col) begin
            win_prev_in = '0;
            win_last_in = '0;
         end else begin
            win_prev_in = win_last_ff;
            win_last_in = cur_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         win_prev_ff <= '0;
         win_last_ff <= '0;
         bypass_ff   <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         win_prev_ff <= win_prev_in;
         win_last_ff <= win_last_in;
         bypass_ff   <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bypass_in) begin
         bypass_data_ff <= line_wr;
      end
   end

   // ---------------- evaluation stage ----------------
   assign s1_v1_in = req_fire && row_ge1 && (col_ff != '0);
   assign s1_v2_in = req_fire && row_ge1 && last_col;
   assign s1_n_in  = {1'b0, s1_v1_in} + {1'b0, s1_v2_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v1_ff <= 1'b0;
         s1_n_ff  <= 2'd0;
      end else begin
         s1_v1_ff <= s1_v1_in;
         s1_n_ff  <= s1_n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_left_ff  <= win_prev_ff;
         s1_mid_ff   <= win_last_ff;
         s1_right_ff <= cur_col;
         s1_last_ff  <= flush_row;
      end
   end

   assign zero_col = '0;

   wwg_group u_group_a (
      .left       (s1_left_ff),
      .centre     (s1_mid_ff),
      .right      (s1_right_ff),
      .next_group (group_a)
   );

   // last group of the row: the column beyond the edge counts as empty
   wwg_group u_group_b (
      .left       (s1_mid_ff),
      .centre     (s1_right_ff),
      .right      (zero_col),
      .next_group (group_b)
   );

   // ---------------- result queue ----------------
   assign slot0_data = s1_v1_ff ? {1'b0, group_a} : {s1_last_ff, group_b};
   assign slot1_data = {s1_last_ff, group_b};

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (fifo_count_ff != '0);
   assign rsp_tdata  = fifo_mem_ff[fifo_rd_ff][7:0];
   assign rsp_tlast  = fifo_mem_ff[fifo_rd_ff][8];

   assign fifo_wr_in    = fifo_wr_ff + FIFO_PTR_W'(s1_n_ff);
   assign fifo_rd_in    = rsp_fire ? fifo_rd_ff + FIFO_PTR_W'(1) : fifo_rd_ff;
   assign fifo_count_in = fifo_count_ff + FIFO_CNT_W'(s1_n_ff)
                          - FIFO_CNT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff    <= '0;
         fifo_rd_ff    <= '0;
         fifo_count_ff <= '0;
      end else begin
         fifo_wr_ff    <= fifo_wr_in;
         fifo_rd_ff    <= fifo_rd_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_n_ff != 2'd0) begin
         fifo_mem_ff[fifo_wr_ff] <= slot0_data;
      end
      if (s1_n_ff == 2'd2) begin
         fifo_mem_ff[fifo_wr_ff + FIFO_PTR_W'(1)] <= slot1_data;
      end
   end

   // ---------------- assertions ----------------
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fifo_count_ff} + {{(FIFO_CNT_W-1){1'b0}}, s1_n_ff})
         <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
      else $error("result queue overrun");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_col) |=> (col_ff == '0))
      else $error("column did not return to zero at end of row");

   a_bypass_src: assert property (@(posedge clock) disable iff (reset)
      bypass_ff |-> $past(req_fire))
      else $error("line store forwarding without a preceding transaction");

   a_first_row_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !row_ge1) |=> (s1_n_ff == 2'd0))
      else $error("result produced for the first row");

endmodule
